// ===== src/rcpw_pkg.sv =====
// Shared types and constants for the RC pulse width capture block.
package rcpw_pkg;

  localparam int NUM_CHANNELS = 6;

  localparam int CHANNEL_W = 3;
  localparam int TIME_W    = 32;
  localparam int WIDTH_W   = 16;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd1000;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2000;

  typedef enum logic {
    CFG_MIN_WIDTH = 1'b0,
    CFG_MAX_WIDTH = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_LOW     = 2'd1,
    PH_HIGH    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic               clamped_low;
    logic               clamped_high;
  } clamp_result_t;

endpackage

// ===== src/rcpw_width_calc.sv =====
// Pulse width from a rise and fall timestamp, clamped to the configured bounds.
module rcpw_width_calc (
  input  logic [rcpw_pkg::TIME_W-1:0]  fall_time,
  input  logic [rcpw_pkg::TIME_W-1:0]  rise_time,
  input  logic [rcpw_pkg::WIDTH_W-1:0] min_width,
  input  logic [rcpw_pkg::WIDTH_W-1:0] max_width,
  output rcpw_pkg::clamp_result_t      result
);
  import rcpw_pkg::*;

  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] raised;
  logic              below_min;
  logic              above_max;

  always_comb begin
    diff      = fall_time - rise_time;
    below_min = diff < TIME_W'(min_width);
    raised    = below_min ? TIME_W'(min_width) : diff;
    above_max = raised > TIME_W'(max_width);
    result.width        = above_max ? max_width : raised[WIDTH_W-1:0];
    result.clamped_low  = below_min;
    result.clamped_high = above_max;
  end

endmodule

// ===== src/rc_pulse_width_capture.sv =====
// Top level of the RC pulse width capture block.
// Each request is a level change on one command channel with its microsecond timestamp, and
// each one returns exactly one result: the channel, whether a high pulse just ended, the
// channel's stored width and the clamp flags. A request is registered on entry and its result
// is registered in the output stage; one request can be taken every cycle while the output is
// not stalled by m_axis_tready. The per-channel phase, rise time and width are updated at the
// same edge that captures the result, so back-to-back requests on one channel see each other's effect.
module rc_pulse_width_capture (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // channel[2:0], pin_level[3], time_us[35:4], zero padding[39:36]
  input  logic [rcpw_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // out_channel[2:0], pulse_done[3], width[19:4], clamped_low[20], clamped_high[21], zero[23:22]
  output logic [rcpw_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [rcpw_pkg::WIDTH_W-1:0]         cfg_data
);
  import rcpw_pkg::*;

  logic [WIDTH_W-1:0] min_width;
  logic [WIDTH_W-1:0] max_width;

  logic                 in_valid;
  logic [CHANNEL_W-1:0] in_channel;
  logic                 in_level;
  logic [TIME_W-1:0]    in_time;

  phase_t             phase [NUM_CHANNELS];
  logic [TIME_W-1:0]  rise  [NUM_CHANNELS];
  logic [WIDTH_W-1:0] stored[NUM_CHANNELS];

  logic                 out_valid;
  logic [CHANNEL_W-1:0] out_channel;
  logic                 out_done;
  clamp_result_t        out_result;

  logic                 advance;
  logic                 in_range;
  phase_t               phase_cur;
  logic [TIME_W-1:0]    rise_cur;
  logic [WIDTH_W-1:0]   stored_cur;
  logic                 pulse_start;
  logic                 pulse_end;
  clamp_result_t        calc;
  clamp_result_t        result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_width <= MIN_WIDTH_RESET;
      max_width <= MAX_WIDTH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_MIN_WIDTH: min_width <= cfg_data;
        CFG_MAX_WIDTH: max_width <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_channel <= s_axis_tdata[CHANNEL_W-1:0];
      in_level   <= s_axis_tdata[CHANNEL_W];
      in_time    <= s_axis_tdata[CHANNEL_W+1 +: TIME_W];
    end
  end

  always_comb begin
    in_range   = int'(in_channel) < NUM_CHANNELS;
    phase_cur  = PH_UNKNOWN;
    rise_cur   = '0;
    stored_cur = '0;
    if (in_range) begin
      phase_cur  = phase[in_channel];
      rise_cur   = rise[in_channel];
      stored_cur = stored[in_channel];
    end
  end

  rcpw_width_calc u_width_calc (
    .fall_time (in_time),
    .rise_time (rise_cur),
    .min_width (min_width),
    .max_width (max_width),
    .result    (calc)
  );

  always_comb begin
    pulse_start = 1'b0;
    pulse_end   = 1'b0;
    if (in_range) begin
      case (phase_cur)
        PH_HIGH: pulse_end   = !in_level;
        default: pulse_start = in_level;
      endcase
    end
  end

  always_comb begin
    result_next = '0;
    if (pulse_end) begin
      result_next = calc;
    end else if (in_range) begin
      result_next.width = stored_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase[i]  <= PH_UNKNOWN;
        stored[i] <= '0;
      end
    end else if (advance) begin
      if (pulse_start) begin
        phase[in_channel] <= PH_HIGH;
      end else if (pulse_end) begin
        phase[in_channel]  <= PH_LOW;
        stored[in_channel] <= calc.width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pulse_start) begin
      rise[in_channel] <= in_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_channel <= in_channel;
      out_done    <= pulse_end;
      out_result  <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_result.clamped_high, out_result.clamped_low,
                          out_result.width, out_done, out_channel};

endmodule
